// ===== hdl/pds_pkg.sv =====
package pds_pkg;

	localparam int GRID_COLS_DEF = 256;
	localparam int GRID_ROWS_DEF = 256;

	// Cell indexes are carried at the width of the largest supported grid.
	localparam int IDX_W = 10;

	localparam int CMD_DEPTH = 4;

	localparam logic [7:0]  RADIUS_RESET = 8'd200;
	localparam logic [15:0] SCALE_RESET  = 16'd256;
	localparam logic [31:0] PEAK_RESET   = 32'h0001_0000;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_DEPOSIT = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_DEPOSIT,
		CMD_READ,
		CMD_SKIP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic [IDX_W-1:0]   ilo;
		logic [IDX_W-1:0]   ihi;
		logic [IDX_W-1:0]   jlo;
		logic [IDX_W-1:0]   jhi;
		logic [7:0]         col;
		logic [7:0]         row;
		logic               rd_in;
	} cmd_t;

	typedef struct packed {
		logic [31:0] cell_density;
		logic [31:0] peak_density;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        saturated;
	} res_t;

endpackage

// ===== hdl/pds_ram.sv =====
module pds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/pds_front.sv =====
module pds_front #(
	parameter int GRID_COLS = pds_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = pds_pkg::GRID_ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         op,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [7:0]         cell_col,
	input  logic [7:0]         cell_row,
	input  logic [7:0]         radius,
	input  logic               hold,
	output logic               cmd_valid,
	input  logic               cmd_pop,
	output pds_pkg::cmd_t      cmd
);
	import pds_pkg::*;

	localparam int PTR_W = $clog2(CMD_DEPTH);
	localparam logic signed [18:0] X_OFFS  = 19'(16 * GRID_COLS);
	localparam logic signed [18:0] Y_OFFS  = 19'(16 * GRID_ROWS);
	localparam logic signed [14:0] COL_MAX = 15'(GRID_COLS - 1);
	localparam logic signed [14:0] ROW_MAX = 15'(GRID_ROWS - 1);

	// Rounds half away from zero to whole units, then halves toward zero.
	function automatic logic signed [13:0] centre(input logic signed [15:0] pos,
			input logic signed [18:0] offs);
		logic signed [18:0] v;
		logic [18:0]        mag;
		logic [14:0]        rnd;
		logic [13:0]        half;
		v    = 19'(pos) + offs;
		mag  = v[18] ? 19'(-v) : 19'(v);
		rnd  = 15'((mag + 19'd8) >> 4);
		half = 14'(rnd >> 1);
		return v[18] ? -$signed(half) : $signed(half);
	endfunction

	logic signed [13:0] ci, cj;
	logic signed [14:0] rad_s, xlo, xhi, ylo, yhi, xlo_c, xhi_c, ylo_c, yhi_c;
	logic               box_empty, accept;
	cmd_t               new_cmd;

	cmd_t             q_mem [CMD_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;

	always_comb begin
		ci    = centre(pos_x, X_OFFS);
		cj    = centre(pos_y, Y_OFFS);
		rad_s = $signed({7'b0, radius});
		xlo   = 15'(ci) - rad_s;
		xhi   = 15'(ci) + rad_s;
		ylo   = 15'(cj) - rad_s;
		yhi   = 15'(cj) + rad_s;
		xlo_c = (xlo < 0) ? '0 : xlo;
		xhi_c = (xhi > COL_MAX) ? COL_MAX : xhi;
		ylo_c = (ylo < 0) ? '0 : ylo;
		yhi_c = (yhi > ROW_MAX) ? ROW_MAX : yhi;
		box_empty = (xlo_c > xhi_c) || (ylo_c > yhi_c) || (radius == 8'd0);

		new_cmd       = '0;
		new_cmd.sx    = pos_x;
		new_cmd.sy    = pos_y;
		new_cmd.ilo   = xlo_c[IDX_W-1:0];
		new_cmd.ihi   = xhi_c[IDX_W-1:0];
		new_cmd.jlo   = ylo_c[IDX_W-1:0];
		new_cmd.jhi   = yhi_c[IDX_W-1:0];
		new_cmd.col   = cell_col;
		new_cmd.row   = cell_row;
		new_cmd.rd_in = (32'(cell_col) < GRID_COLS) && (32'(cell_row) < GRID_ROWS);
		unique case (op_t'(op))
			OP_CLEAR:   new_cmd.kind = CMD_CLEAR;
			OP_DEPOSIT: new_cmd.kind = box_empty ? CMD_SKIP : CMD_DEPOSIT;
			OP_READ:    new_cmd.kind = CMD_READ;
			default:    new_cmd.kind = CMD_SKIP;
		endcase
	end

	assign full      = (cnt_q == (PTR_W + 1)'(CMD_DEPTH)) || hold;
	assign accept    = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem[wr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				wr_q <= wr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W + 1)'(accept) - (PTR_W + 1)'(cmd_pop);
		end
	end
endmodule

// ===== hdl/pds_sqrt.sv =====
module pds_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] value,
	output logic [23:0] root,
	output logic        done
);
	localparam logic [4:0] LAST_STEP = 5'd23;

	logic [47:0] rem_q, res_q, bit_q, trial;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;

	assign trial = res_q + bit_q;

	// One result bit per cycle, from the top pair of bits down.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= 48'h4000_0000_0000;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign root = res_q[23:0];
	assign done = done_q;
endmodule

// ===== hdl/pds_div.sv =====
module pds_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	input  logic [4:0]  steps,
	output logic [23:0] quot,
	output logic        done
);
	logic [63:0] rem_q, den_q;
	logic [23:0] quot_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q, fits;

	// The divisor arrives already shifted to line up with the top quotient bit.
	assign fits = (rem_q >= den_q);

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - den_q;
			end
			quot_q <= {quot_q[22:0], fits};
			den_q  <= den_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot = quot_q;
	assign done = done_q;
endmodule

// ===== hdl/pds_back.sv =====
module pds_back #(
	parameter int GRID_COLS = pds_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = pds_pkg::GRID_ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_pop,
	input  pds_pkg::cmd_t cmd,
	input  logic [7:0]    radius,
	input  logic [15:0]   scale,
	input  logic          pop,
	output logic          res_valid,
	output pds_pkg::res_t res,
	output logic          init_busy
);
	import pds_pkg::*;

	localparam int CELLS = GRID_COLS * GRID_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [AW-1:0]      SWEEP_LAST = AW'(CELLS - 1);
	localparam logic signed [17:0] X_CENTRE   = 18'(16 * GRID_COLS);
	localparam logic signed [17:0] Y_CENTRE   = 18'(16 * GRID_ROWS);
	localparam logic [4:0]         W_STEPS    = 5'd24;
	localparam logic [4:0]         C_STEPS    = 5'd9;

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_CLEAR,
		ST_DX, ST_DY, ST_DSQ, ST_SQRT, ST_ASQ, ST_MLO, ST_MHI, ST_DIVW, ST_ACC, ST_NEXT,
		ST_RADDR, ST_RDATA, ST_RMIN, ST_RSEG, ST_RDST, ST_RDIV,
		ST_DONE
	} back_state_t;

	typedef enum logic [1:0] {
		SEG_RED,
		SEG_YELLOW,
		SEG_WHITE
	} heat_seg_t;

	back_state_t state_q, state_d;

	cmd_t             cur_q;
	logic [AW-1:0]    sweep_q, addr_q;
	logic [IDX_W-1:0] i_q, j_q;
	logic [31:0]      peak_q, acc_q, cell_q, c_q, m_q;
	logic [7:0]       red_q, green_q, blue_q;
	logic             sat_q, res_valid_q;
	res_t             res_q;
	logic signed [17:0] dx_q, dy_q;
	logic [35:0]      dx2_q;
	logic [23:0]      a_q, w_q;
	logic [47:0]      a2_q;
	logic [39:0]      nlo_q;
	logic [38:0]      num_q, den_q;
	heat_seg_t        seg_q;

	logic [AW-1:0]      cell_addr, rd_addr, ram_waddr, ram_raddr;
	logic [31:0]        ram_wdata, ram_rdata, acc_sum;
	logic               ram_we, sqrt_start, sqrt_done, div_start, div_done;
	logic [23:0]        sqrt_root, quot, rq;
	logic [15:0]        rr;
	logic [23:0]        lim;
	logic signed [17:0] cx16, cy16;
	logic signed [35:0] dyy;
	logic [36:0]        dsq;
	logic [32:0]        sum;
	logic [39:0]        nhi;
	logic [63:0]        div_num, div_den;
	logic [4:0]         div_steps;
	logic [38:0]        c100, m33, m66, m34;
	logic [7:0]         chan;
	logic               last_cell;

	assign cell_addr = AW'(32'(j_q) * GRID_COLS + 32'(i_q));
	assign rd_addr   = AW'(32'(cur_q.row) * GRID_COLS + 32'(cur_q.col));
	assign rr        = {8'b0, radius} * {8'b0, radius};
	assign lim       = {rr, 8'b0};
	assign rq        = {radius, 16'b0};
	assign cx16      = $signed({3'b0, i_q, 5'b0}) - X_CENTRE;
	assign cy16      = $signed({3'b0, j_q, 5'b0}) - Y_CENTRE;
	assign dyy       = dy_q * dy_q;
	assign dsq       = {1'b0, dx2_q} + {1'b0, 36'(dyy)};
	assign sum       = {1'b0, acc_q} + {9'b0, w_q};
	assign acc_sum   = sum[32] ? '1 : sum[31:0];
	assign nhi       = a2_q[47:24] * scale;
	assign c100      = 39'(c_q) * 39'd100;
	assign m33       = 39'(m_q) * 39'd33;
	assign m66       = 39'(m_q) * 39'd66;
	assign m34       = 39'(m_q) * 39'd34;
	assign chan      = (quot > 24'd255) ? 8'd255 : quot[7:0];
	assign last_cell = (i_q == cur_q.ihi) && (j_q == cur_q.jhi);

	always_comb begin
		if (state_q == ST_MHI) begin
			div_num   = {nhi, 24'b0} + {24'b0, nlo_q};
			div_den   = {1'b0, rr, 47'b0};
			div_steps = W_STEPS;
		end else begin
			div_num   = 64'(num_q) * 64'd510 + 64'(den_q);
			div_den   = {16'b0, den_q, 9'b0};
			div_steps = C_STEPS;
		end
	end

	pds_ram #(.WIDTH(32), .DEPTH(CELLS)) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pds_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  ({dsq[23:0], 24'b0}),
		.root   (sqrt_root),
		.done   (sqrt_done)
	);

	pds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.quot   (quot),
		.done   (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = sweep_q;
		ram_wdata  = '0;
		ram_raddr  = cell_addr;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
				if (sweep_q == SWEEP_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					unique case (cmd.kind)
						CMD_CLEAR:   state_d = ST_CLEAR;
						CMD_DEPOSIT: state_d = ST_DX;
						CMD_READ:    state_d = ST_RADDR;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (sweep_q == SWEEP_LAST) state_d = ST_DONE;
			end
			ST_DX:  state_d = ST_DY;
			ST_DY:  state_d = ST_DSQ;
			ST_DSQ: begin
				if (dsq < 37'(lim)) begin
					sqrt_start = 1'b1;
					state_d    = ST_SQRT;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_SQRT: if (sqrt_done) state_d = ST_ASQ;
			ST_ASQ:  state_d = ST_MLO;
			ST_MLO:  state_d = ST_MHI;
			ST_MHI: begin
				div_start = 1'b1;
				state_d   = ST_DIVW;
			end
			ST_DIVW: if (div_done) state_d = ST_ACC;
			ST_ACC: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q;
				ram_wdata = acc_sum;
				state_d   = ST_NEXT;
			end
			ST_NEXT:  state_d = last_cell ? ST_DONE : ST_DX;
			ST_RADDR: begin
				ram_raddr = rd_addr;
				state_d   = ST_RDATA;
			end
			ST_RDATA: state_d = ST_RMIN;
			ST_RMIN:  state_d = ST_RSEG;
			ST_RSEG:  state_d = ST_RDST;
			ST_RDST: begin
				div_start = 1'b1;
				state_d   = ST_RDIV;
			end
			ST_RDIV: if (div_done) state_d = ST_DONE;
			ST_DONE: if (!res_valid_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath registers; every value here is consumed only in a state that follows its load.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_q   <= cmd;
				i_q     <= cmd.ilo;
				j_q     <= cmd.jlo;
				cell_q  <= '0;
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
			end
			ST_DX: begin
				addr_q <= cell_addr;
				dx_q   <= 18'(cur_q.sx) - cx16;
				dy_q   <= 18'(cur_q.sy) - cy16;
			end
			ST_DY: begin
				acc_q <= ram_rdata;
				dx2_q <= 36'(dx_q * dx_q);
			end
			ST_SQRT: a_q  <= (sqrt_root < rq) ? rq - sqrt_root : '0;
			ST_ASQ:  a2_q <= a_q * a_q;
			ST_MLO:  nlo_q <= a2_q[23:0] * scale;
			ST_DIVW: w_q  <= quot;
			ST_NEXT: begin
				if (i_q == cur_q.ihi) begin
					i_q <= cur_q.ilo;
					j_q <= j_q + 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_RDATA: cell_q <= cur_q.rd_in ? ram_rdata : '0;
			ST_RMIN: begin
				m_q <= (peak_q != '0) ? peak_q : PEAK_RESET;
				c_q <= (cell_q < ((peak_q != '0) ? peak_q : PEAK_RESET)) ?
					cell_q : ((peak_q != '0) ? peak_q : PEAK_RESET);
			end
			ST_RSEG: begin
				if (c100 < m33) begin
					seg_q <= SEG_RED;
					num_q <= c100;
					den_q <= m33;
				end else if (c100 < m66) begin
					seg_q <= SEG_YELLOW;
					num_q <= c100 - m33;
					den_q <= m33;
				end else begin
					seg_q <= SEG_WHITE;
					num_q <= c100 - m66;
					den_q <= m34;
				end
			end
			ST_RDIV: begin
				if (div_done) begin
					case (seg_q)
						SEG_RED: red_q <= chan;
						SEG_YELLOW: begin
							red_q   <= 8'd255;
							green_q <= chan;
						end
						default: begin
							red_q   <= 8'd255;
							green_q <= 8'd255;
							blue_q  <= chan;
						end
					endcase
				end
			end
			ST_DONE: begin
				if (!res_valid_q) begin
					res_q.cell_density <= cell_q;
					res_q.peak_density <= peak_q;
					res_q.red          <= red_q;
					res_q.green        <= green_q;
					res_q.blue         <= blue_q;
					res_q.saturated    <= sat_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			peak_q      <= PEAK_RESET;
			sat_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_INIT || state_q == ST_CLEAR) begin
				sweep_q <= (sweep_q == SWEEP_LAST) ? '0 : sweep_q + 1'b1;
			end
			if (state_q == ST_CLEAR && sweep_q == SWEEP_LAST) begin
				peak_q <= '0;
			end
			if (state_q == ST_IDLE) begin
				sat_q <= 1'b0;
			end
			if (state_q == ST_ACC) begin
				sat_q <= sat_q | sum[32];
				if (acc_sum > peak_q) begin
					peak_q <= acc_sum;
				end
			end
			if (state_q == ST_DONE && !res_valid_q) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign init_busy = (state_q == ST_INIT);
endmodule

// ===== hdl/particle_density_splat_unit.sv =====
// Particle density grid with kernel deposition and a heat-colour read-out. Items are pushed
// into a four-entry command queue and carried out one at a time; results leave through a
// one-entry result register, so new items are taken while a result waits to be popped.
// A clear writes one cell per cycle over all GRID_COLS*GRID_ROWS cells (65536 at the
// default size). A deposit visits each cell of the clipped box: a cell outside the radius
// is only tested, while each cell inside it runs the 24-step square root and then the
// 24-step weight divider. A read spends most of its time in the 9-step divider for the
// colour channel. Right after reset the grid is zeroed in one pass over all cells, during
// which full stays high; configuration writes are taken at any time.
module particle_density_splat_unit #(
	parameter int GRID_COLS = pds_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = pds_pkg::GRID_ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         op,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic [7:0]         cell_col,
	input  logic [7:0]         cell_row,
	output logic               empty,
	input  logic               pop,
	output logic [31:0]        cell_density,
	output logic [31:0]        peak_density,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               saturated
);
	import pds_pkg::*;

	localparam logic [0:0] CFG_RADIUS = 1'b0;
	localparam logic [0:0] CFG_SCALE  = 1'b1;

	logic [7:0]  radius_q;
	logic [15:0] scale_q;
	logic        cmd_valid, cmd_pop, res_valid, init_busy;
	cmd_t        cmd;
	res_t        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			scale_q  <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RADIUS: radius_q <= cfg_data[7:0];
				CFG_SCALE:  scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	pds_front #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.op        (op),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.cell_col  (cell_col),
		.cell_row  (cell_row),
		.radius    (radius_q),
		.hold      (init_busy),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	pds_back #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.radius    (radius_q),
		.scale     (scale_q),
		.pop       (pop),
		.res_valid (res_valid),
		.res       (res),
		.init_busy (init_busy)
	);

	assign empty        = !res_valid;
	assign cell_density = res.cell_density;
	assign peak_density = res.peak_density;
	assign red          = res.red;
	assign green        = res.green;
	assign blue         = res.blue;
	assign saturated    = res.saturated;

	// No transaction may enter while the grid is still being cleared after reset.
	assert property (@(posedge clk) disable iff (!arst_n) init_busy |-> full)
		else $error("input open during the reset clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n) init_busy |-> empty)
		else $error("result produced during the reset clearing pass");

	assert property (@(posedge clk) disable iff (!arst_n) cmd_pop |-> cmd_valid)
		else $error("command queue popped while empty");
endmodule
